/* src/hsc_pkg.sv */
package hsc_pkg;

  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] SYL_LAST   = 16'hD7A3;
  localparam logic [15:0] CONS_FIRST = 16'h3131;
  localparam logic [15:0] CONS_LAST  = 16'h314E;
  localparam logic [15:0] VOW_FIRST  = 16'h314F;
  localparam logic [15:0] VOW_LAST   = 16'h3163;

  // Marks a consonant with no initial form and a vowel pair that does not join
  localparam logic [4:0] NO_INIT  = 5'd31;
  localparam logic [4:0] NO_VOWEL = 5'd31;

  // Reciprocals: x/28 = ((x>>2)*RECIP_7)>>17, x/588 = ((x>>2)*RECIP_147)>>19
  localparam logic [14:0] RECIP_7   = 15'd18725;
  localparam logic [11:0] RECIP_147 = 12'd3567;

  typedef struct packed {
    logic        t_cons;
    logic        t_vow;
    logic        p_cons;
    logic        p_syl;
    logic [15:0] p;
    logic [13:0] x;
    logic [8:0]  q;
    logic [4:0]  c1;
    logic [4:0]  tc;
    logic [4:0]  tv;
    logic [4:0]  pc;
  } mid_t;

  typedef struct packed {
    logic        new_valid;
    logic [15:0] new_syllable;
    logic        prior_replaced;
    logic [15:0] prior_syllable;
  } res_t;

  function automatic logic [4:0] init_of_cons(input logic [4:0] idx);
    logic [4:0] r;
    case (idx)
      5'd0:  r = 5'd0;
      5'd1:  r = 5'd1;
      5'd3:  r = 5'd2;
      5'd6:  r = 5'd3;
      5'd7:  r = 5'd4;
      5'd8:  r = 5'd5;
      5'd16: r = 5'd6;
      5'd17: r = 5'd7;
      5'd18: r = 5'd8;
      5'd20: r = 5'd9;
      5'd21: r = 5'd10;
      5'd22: r = 5'd11;
      5'd23: r = 5'd12;
      5'd24: r = 5'd13;
      5'd25: r = 5'd14;
      5'd26: r = 5'd15;
      5'd27: r = 5'd16;
      5'd28: r = 5'd17;
      5'd29: r = 5'd18;
      default: r = NO_INIT;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] final_of_cons(input logic [4:0] idx);
    logic [4:0] r;
    case (idx)
      5'd0:  r = 5'd1;
      5'd1:  r = 5'd2;
      5'd2:  r = 5'd3;
      5'd3:  r = 5'd4;
      5'd4:  r = 5'd5;
      5'd5:  r = 5'd6;
      5'd6:  r = 5'd7;
      5'd8:  r = 5'd8;
      5'd9:  r = 5'd9;
      5'd10: r = 5'd10;
      5'd11: r = 5'd11;
      5'd12: r = 5'd12;
      5'd13: r = 5'd13;
      5'd14: r = 5'd14;
      5'd15: r = 5'd15;
      5'd16: r = 5'd16;
      5'd17: r = 5'd17;
      5'd19: r = 5'd18;
      5'd20: r = 5'd19;
      5'd21: r = 5'd20;
      5'd22: r = 5'd21;
      5'd23: r = 5'd22;
      5'd25: r = 5'd23;
      5'd26: r = 5'd24;
      5'd27: r = 5'd25;
      5'd28: r = 5'd26;
      5'd29: r = 5'd27;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] keep_of_final(input logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd3:  r = 5'd1;
      5'd5:  r = 5'd4;
      5'd6:  r = 5'd4;
      5'd9:  r = 5'd8;
      5'd10: r = 5'd8;
      5'd11: r = 5'd8;
      5'd12: r = 5'd8;
      5'd13: r = 5'd8;
      5'd14: r = 5'd8;
      5'd15: r = 5'd8;
      5'd18: r = 5'd17;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] lead_of_final(input logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd2:  r = 5'd1;
      5'd3:  r = 5'd9;
      5'd4:  r = 5'd2;
      5'd5:  r = 5'd12;
      5'd6:  r = 5'd18;
      5'd7:  r = 5'd3;
      5'd8:  r = 5'd5;
      5'd10: r = 5'd6;
      5'd11: r = 5'd7;
      5'd12: r = 5'd9;
      5'd13: r = 5'd16;
      5'd14: r = 5'd17;
      5'd15: r = 5'd18;
      5'd16: r = 5'd6;
      5'd17: r = 5'd7;
      5'd18: r = 5'd9;
      5'd19: r = 5'd9;
      5'd20: r = 5'd10;
      5'd21: r = 5'd11;
      5'd22: r = 5'd12;
      5'd23: r = 5'd14;
      5'd24: r = 5'd15;
      5'd25: r = 5'd16;
      5'd26: r = 5'd17;
      5'd27: r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] join_finals(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (a == 5'd1 && b == 5'd19) r = 5'd3;
    if (a == 5'd4 && b == 5'd22) r = 5'd5;
    if (a == 5'd4 && b == 5'd27) r = 5'd6;
    if (a == 5'd8 && b == 5'd1) r = 5'd9;
    if (a == 5'd8 && b == 5'd16) r = 5'd10;
    if (a == 5'd8 && b == 5'd17) r = 5'd11;
    if (a == 5'd8 && b == 5'd19) r = 5'd12;
    if (a == 5'd8 && b == 5'd25) r = 5'd13;
    if (a == 5'd8 && b == 5'd26) r = 5'd14;
    if (a == 5'd8 && b == 5'd27) r = 5'd15;
    if (a == 5'd17 && b == 5'd19) r = 5'd18;
    return r;
  endfunction

  function automatic logic [4:0] join_vowels(input logic [4:0] a, input logic [4:0] b);
    logic [4:0] r;
    r = NO_VOWEL;
    if (a == 5'd8 && b == 5'd0) r = 5'd9;
    if (a == 5'd8 && b == 5'd1) r = 5'd10;
    if (a == 5'd8 && b == 5'd20) r = 5'd11;
    if (a == 5'd13 && b == 5'd4) r = 5'd14;
    if (a == 5'd13 && b == 5'd5) r = 5'd15;
    if (a == 5'd13 && b == 5'd20) r = 5'd16;
    if (a == 5'd18 && b == 5'd20) r = 5'd19;
    return r;
  endfunction

  function automatic logic [15:0] mul28(input logic [4:0] a);
    return {6'b0, a, 5'b0} - {9'b0, a, 2'b0};
  endfunction

  function automatic logic [15:0] mul588(input logic [4:0] a);
    return {2'b0, a, 9'b0} + {5'b0, a, 6'b0} + {8'b0, a, 3'b0} + {9'b0, a, 2'b0};
  endfunction

endpackage

/* src/hsc_split.sv */
module hsc_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [15:0]         typed,
  input  logic [15:0]         prior,
  output logic                mid_vld,
  output hsc_pkg::mid_t       mid
);
  import hsc_pkg::*;

  logic        vld_r;
  mid_t        mid_r;
  mid_t        mid_nxt;
  logic [15:0] x16;
  logic [15:0] tc16;
  logic [15:0] tv16;
  logic [15:0] pc16;
  logic [26:0] prod_q;
  logic [23:0] prod_c1;

  always_comb begin
    x16     = prior - SYL_BASE;
    tc16    = typed - CONS_FIRST;
    tv16    = typed - VOW_FIRST;
    pc16    = prior - CONS_FIRST;
    // split syllable index: x/28 and x/588 by reciprocal multiply
    prod_q  = {15'b0, x16[13:2]} * {12'b0, RECIP_7};
    prod_c1 = {12'b0, x16[13:2]} * {12'b0, RECIP_147};

    mid_nxt.t_cons = (typed >= CONS_FIRST) && (typed <= CONS_LAST);
    mid_nxt.t_vow  = (typed >= VOW_FIRST) && (typed <= VOW_LAST);
    mid_nxt.p_cons = (prior >= CONS_FIRST) && (prior <= CONS_LAST);
    mid_nxt.p_syl  = (prior >= SYL_BASE) && (prior <= SYL_LAST);
    mid_nxt.p      = prior;
    mid_nxt.x      = x16[13:0];
    mid_nxt.q      = prod_q[25:17];
    mid_nxt.c1     = prod_c1[23:19];
    mid_nxt.tc     = tc16[4:0];
    mid_nxt.tv     = tv16[4:0];
    mid_nxt.pc     = pc16[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  assign mid_vld = vld_r;
  assign mid     = mid_r;

endmodule

/* src/hsc_compose.sv */
module hsc_compose (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_vld,
  input  hsc_pkg::mid_t       mid,
  output logic                res_vld,
  output hsc_pkg::res_t       res
);
  import hsc_pkg::*;

  logic        vld_r;
  res_t        res_r;
  res_t        res_nxt;
  logic [8:0]  c1_21;
  logic [8:0]  v9;
  logic [4:0]  v;
  logic [13:0] q28;
  logic [13:0] c2_14;
  logic [4:0]  c2;
  logic [4:0]  f0;
  logic [4:0]  f;
  logic [4:0]  nv;
  logic [4:0]  ini;
  logic        ok;
  logic        repl;
  logic [15:0] made;
  logic [15:0] prev;

  always_comb begin
    c1_21 = {4'b0, mid.c1} * 9'd21;
    v9    = mid.q - c1_21;
    v     = v9[4:0];
    q28   = {mid.q, 5'b0} - {3'b0, mid.q, 2'b0};
    c2_14 = mid.x - q28;
    c2    = c2_14[4:0];
    f0    = final_of_cons(mid.tc);
    f     = (f0 != 5'd0 && c2 != 5'd0) ? join_finals(c2, f0) : f0;
    nv    = join_vowels(v, mid.tv);
    ini   = init_of_cons(mid.pc);
    ok    = 1'b0;
    repl  = 1'b0;
    made  = 16'd0;
    prev  = 16'd0;

    if (mid.p_syl && (mid.t_cons || mid.t_vow)) begin
      if (mid.t_cons) begin
        // swap the final in place
        if (f != 5'd0) begin
          made = mid.p - {11'b0, c2} + {11'b0, f};
          ok   = 1'b1;
        end
      end else if (c2 != 5'd0) begin
        // move the final (or its second half) onto a new syllable
        prev = mid.p - {11'b0, c2} + {11'b0, keep_of_final(c2)};
        made = SYL_BASE + mul588(lead_of_final(c2)) + mul28(mid.tv);
        ok   = 1'b1;
        repl = 1'b1;
      end else if (nv != NO_VOWEL) begin
        made = mid.p + mul28(nv) - mul28(v);
        ok   = 1'b1;
      end
    end else if (mid.p_cons && mid.t_vow) begin
      if (ini != NO_INIT) begin
        made = SYL_BASE + mul588(ini) + mul28(mid.tv);
        ok   = 1'b1;
      end
    end

    res_nxt.new_valid      = ok;
    res_nxt.new_syllable   = ok ? made : 16'd0;
    res_nxt.prior_replaced = ok && repl;
    res_nxt.prior_syllable = (ok && repl) ? prev : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= mid_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = vld_r;
  assign res     = res_r;

endmodule

/* src/hangul_syllable_composer_core.sv */
// Hangul syllable composer.
// Input channel: drive in_typed_code (key just typed) and in_prior_code
// (previous character) with start high; the item is taken at any edge where
// start is high and busy is low. busy is always low: one item per cycle.
// Result channel: every item gives exactly one result. out_strobe is high for
// one cycle with out_new_valid, out_new_syllable, out_prior_replaced and
// out_prior_syllable; the result is taken at the edge that ends that cycle.
// Path: an item taken at an edge passes through the input register, the index
// split register and the result register before its result is shown.
// Throughput: one item per clock, set by the three-register pipeline; the
// split of the syllable index uses two constant reciprocal multiplies.
// The receiver cannot stall, so results are never held back.
// Reset (rst_n low, synchronous) clears all valid bits; no result is shown
// until an item is taken after reset.
module hangul_syllable_composer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_typed_code,
  input  logic [15:0] in_prior_code,
  output logic        out_strobe,
  output logic        out_new_valid,
  output logic [15:0] out_new_syllable,
  output logic        out_prior_replaced,
  output logic [15:0] out_prior_syllable
);
  import hsc_pkg::*;

  logic        in_vld_r;
  logic [15:0] typed_r;
  logic [15:0] prior_r;
  logic        mid_vld;
  mid_t        mid;
  logic        res_vld;
  res_t        res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    typed_r <= in_typed_code;
    prior_r <= in_prior_code;
  end

  hsc_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld_r),
    .typed   (typed_r),
    .prior   (prior_r),
    .mid_vld (mid_vld),
    .mid     (mid)
  );

  hsc_compose u_compose (
    .clk     (clk),
    .rst_n   (rst_n),
    .mid_vld (mid_vld),
    .mid     (mid),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_strobe         = res_vld;
  assign out_new_valid      = res.new_valid;
  assign out_new_syllable   = res.new_syllable;
  assign out_prior_replaced = res.prior_replaced;
  assign out_prior_syllable = res.prior_syllable;

endmodule

/* verif/hangul_composition_checker.sv */
module hangul_composition_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_typed_code,
  input  logic [15:0] in_prior_code,
  input  logic        out_strobe,
  input  logic        out_new_valid,
  input  logic [15:0] out_new_syllable,
  input  logic        out_prior_replaced,
  input  logic [15:0] out_prior_syllable,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsc_pkg::*;

  localparam int NONE = 31;

  typedef struct packed {
    logic        ok;
    logic [15:0] syl;
    logic        repl;
    logic [15:0] prior;
  } syllable_result_t;

  syllable_result_t expected_syllables[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int initial_index(input int k);
    case (k)
      0: return 0;
      1: return 1;
      3: return 2;
      6: return 3;
      7: return 4;
      8: return 5;
      16: return 6;
      17: return 7;
      18: return 8;
      default: return (k >= 20 && k <= 29) ? k - 11 : NONE;
    endcase
  endfunction

  // ssang-digeut, ssang-bieup and ssang-jieut have no final form
  function automatic int final_index(input int k);
    if (k <= 6) return k + 1;
    if (k == 7 || k == 18 || k == 24) return 0;
    if (k <= 17) return k;
    if (k <= 23) return k - 1;
    return k - 2;
  endfunction

  function automatic int kept_final(input int f);
    case (f)
      3: return 1;
      5, 6: return 4;
      9, 10, 11, 12, 13, 14, 15: return 8;
      18: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic int moved_initial(input int f);
    case (f)
      2: return 1;
      3, 12, 18, 19: return 9;
      4: return 2;
      5, 22: return 12;
      6, 15, 27: return 18;
      7: return 3;
      8: return 5;
      10, 16: return 6;
      11, 17: return 7;
      13, 25: return 16;
      14, 26: return 17;
      20: return 10;
      21: return 11;
      23: return 14;
      24: return 15;
      default: return 0;
    endcase
  endfunction

  function automatic int compound_final(input int a, input int b);
    case ({a[4:0], b[4:0]})
      {5'd1, 5'd19}: return 3;
      {5'd4, 5'd22}: return 5;
      {5'd4, 5'd27}: return 6;
      {5'd8, 5'd1}: return 9;
      {5'd8, 5'd16}: return 10;
      {5'd8, 5'd17}: return 11;
      {5'd8, 5'd19}: return 12;
      {5'd8, 5'd25}: return 13;
      {5'd8, 5'd26}: return 14;
      {5'd8, 5'd27}: return 15;
      {5'd17, 5'd19}: return 18;
      default: return 0;
    endcase
  endfunction

  function automatic int compound_vowel(input int a, input int b);
    case ({a[4:0], b[4:0]})
      {5'd8, 5'd0}: return 9;
      {5'd8, 5'd1}: return 10;
      {5'd8, 5'd20}: return 11;
      {5'd13, 5'd4}: return 14;
      {5'd13, 5'd5}: return 15;
      {5'd13, 5'd20}: return 16;
      {5'd18, 5'd20}: return 19;
      default: return NONE;
    endcase
  endfunction

  function automatic logic [15:0] syllable_code(input int lead, input int vow, input int fin);
    return 16'(int'(SYL_BASE) + (lead * 21 + vow) * 28 + fin);
  endfunction

  function automatic syllable_result_t compose_syllable(input logic [15:0] typed,
                                                        input logic [15:0] prior);
    syllable_result_t r;
    int x, lead, vow, fin, f, nv;
    logic t_cons, t_vow, p_cons, p_syl;
    r = '0;
    t_cons = typed >= CONS_FIRST && typed <= CONS_LAST;
    t_vow  = typed >= VOW_FIRST && typed <= VOW_LAST;
    p_cons = prior >= CONS_FIRST && prior <= CONS_LAST;
    p_syl  = prior >= SYL_BASE && prior <= SYL_LAST;
    if (p_syl && (t_cons || t_vow)) begin
      x = int'(prior) - int'(SYL_BASE);
      fin = x % 28;
      vow = (x / 28) % 21;
      lead = x / 588;
      if (t_cons) begin
        f = final_index(int'(typed) - int'(CONS_FIRST));
        if (f != 0 && fin != 0) f = compound_final(fin, f);
        if (f != 0) begin
          r.ok = 1'b1;
          r.syl = syllable_code(lead, vow, f);
        end
      end else if (fin != 0) begin
        // move the final (or its second half) onto the new syllable
        r.ok = 1'b1;
        r.repl = 1'b1;
        r.prior = syllable_code(lead, vow, kept_final(fin));
        r.syl = syllable_code(moved_initial(fin), int'(typed) - int'(VOW_FIRST), 0);
      end else begin
        nv = compound_vowel(vow, int'(typed) - int'(VOW_FIRST));
        if (nv != NONE) begin
          r.ok = 1'b1;
          r.syl = syllable_code(lead, nv, 0);
        end
      end
    end else if (p_cons && t_vow) begin
      lead = initial_index(int'(prior) - int'(CONS_FIRST));
      if (lead != NONE) begin
        r.ok = 1'b1;
        r.syl = syllable_code(lead, int'(typed) - int'(VOW_FIRST), 0);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input bit have_want, input syllable_result_t want,
                                 input syllable_result_t got);
    if (mismatches < 10) begin
      if (have_want)
        $display("%0t mismatch: expected valid=%0b syl=%h repl=%0b prior=%h",
                 $realtime, want.ok, want.syl, want.repl, want.prior);
      else
        $display("%0t mismatch: result with no item outstanding", $realtime);
      $display("%0t           got      valid=%0b syl=%h repl=%0b prior=%h",
               $realtime, got.ok, got.syl, got.repl, got.prior);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    syllable_result_t want, got;
    if (rst_n) begin
      // retire before adding, so a result can never match its own item
      if (out_strobe) begin
        got = {out_new_valid, out_new_syllable, out_prior_replaced, out_prior_syllable};
        if (expected_syllables.size() == 0) begin
          report_mismatch(1'b0, '0, got);
        end else begin
          want = expected_syllables.pop_front();
          if (got.ok !== want.ok || got.syl !== want.syl ||
              got.repl !== want.repl || got.prior !== want.prior)
            report_mismatch(1'b1, want, got);
        end
      end
      if (start && !busy)
        expected_syllables.push_back(compose_syllable(in_typed_code, in_prior_code));
      outstanding <= expected_syllables.size();
    end
  end

endmodule

/* verif/tb_hangul_syllable_composer_core.sv */
module tb_hangul_syllable_composer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hsc_pkg::*;

  localparam int ITEM_COUNT = 1750;
  localparam int CALM_TAIL  = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [15:0] in_typed_code = '0;
  logic [15:0] in_prior_code = '0;
  logic        busy;
  logic        out_strobe;
  logic        out_new_valid;
  logic [15:0] out_new_syllable;
  logic        out_prior_replaced;
  logic [15:0] out_prior_syllable;
  int          mismatches;
  int          outstanding;

  always #4 clk = ~clk;

  hangul_syllable_composer_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_typed_code      (in_typed_code),
    .in_prior_code      (in_prior_code),
    .out_strobe         (out_strobe),
    .out_new_valid      (out_new_valid),
    .out_new_syllable   (out_new_syllable),
    .out_prior_replaced (out_prior_replaced),
    .out_prior_syllable (out_prior_syllable)
  );

  hangul_composition_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_typed_code      (in_typed_code),
    .in_prior_code      (in_prior_code),
    .out_strobe         (out_strobe),
    .out_new_valid      (out_new_valid),
    .out_new_syllable   (out_new_syllable),
    .out_prior_replaced (out_prior_replaced),
    .out_prior_syllable (out_prior_syllable),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  task automatic key_in(input logic [15:0] typed, input logic [15:0] prior);
    in_typed_code <= typed;
    in_prior_code <= prior;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] boundary_code();
    case ($urandom_range(0, 11))
      0: return CONS_FIRST - 16'd1;
      1: return CONS_FIRST;
      2: return CONS_LAST;
      3: return VOW_FIRST;
      4: return VOW_LAST;
      5: return VOW_LAST + 16'd1;
      6: return SYL_BASE - 16'd1;
      7: return SYL_BASE;
      8: return SYL_LAST;
      9: return SYL_LAST + 16'd1;
      10: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic random_key(output logic [15:0] typed, output logic [15:0] prior);
    int pick, lead, vow, fin;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // syllable then jamo, biased toward vowels and finals that compound
      lead = $urandom_range(0, 18);
      vow = $urandom_range(0, 1) ? $urandom_range(0, 20) : 5 * $urandom_range(0, 2) + 8;
      case ($urandom_range(0, 9))
        0, 1, 2: fin = 0;
        3, 4, 5: begin
          case ($urandom_range(0, 3))
            0: fin = 1;
            1: fin = 4;
            2: fin = 8;
            default: fin = 17;
          endcase
        end
        default: fin = $urandom_range(0, 27);
      endcase
      prior = 16'(int'(SYL_BASE) + (lead * 21 + vow) * 28 + fin);
      typed = $urandom_range(0, 1) ? 16'(int'(CONS_FIRST) + $urandom_range(0, 29))
                                   : 16'(int'(VOW_FIRST) + $urandom_range(0, 20));
    end else if (pick < 65) begin
      prior = 16'(int'(CONS_FIRST) + $urandom_range(0, 29));
      typed = ($urandom_range(0, 4) != 0) ? 16'(int'(VOW_FIRST) + $urandom_range(0, 20))
                                          : 16'(int'(CONS_FIRST) + $urandom_range(0, 29));
    end else if (pick < 82) begin
      typed = 16'($urandom);
      prior = 16'($urandom);
    end else begin
      typed = boundary_code();
      prior = boundary_code();
    end
  endtask

  initial begin
    logic [15:0] typed, prior;
    bit bursty;
    int i;
    bursty = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    key_in(16'h0000, 16'h0000);
    key_in(16'hFFFF, 16'hFFFF);
    key_in(16'h314F, 16'h3131);   // first consonant, first vowel
    key_in(16'h3163, 16'h314E);   // last consonant, last vowel
    key_in(16'h314F, 16'h3133);   // compound cluster cannot start a syllable
    key_in(16'h3138, 16'hAC00);   // double consonants with no final form
    key_in(16'h3143, 16'hAC00);
    key_in(16'h3149, 16'hAC00);
    key_in(16'h3131, 16'hAC00);   // add a final
    key_in(16'h314E, 16'hAC00);
    key_in(16'h3145, 16'hAC01);   // compound the final
    key_in(16'h3131, 16'hAC01);   // finals that do not compound
    key_in(16'h314F, 16'hC624);   // compound the vowel
    key_in(16'h3153, 16'hC624);   // vowels that do not compound
    key_in(16'h314F, 16'hAC01);   // move a plain final
    key_in(16'h314F, 16'hAC03);   // split a compound final
    key_in(16'h314F, 16'hAC1B);
    key_in(16'h3163, SYL_LAST);
    key_in(16'h3131, SYL_LAST);
    key_in(16'hAC00, 16'h3131);   // typed syllable
    key_in(16'h314F, 16'h314F);   // prior vowel
    key_in(16'h3131, 16'h3134);   // consonant after consonant
    key_in(16'h3164, 16'h3131);
    key_in(16'h314F, 16'hABFF);
    key_in(16'h314F, 16'hD7A4);

    for (i = 0; i < ITEM_COUNT; i++) begin
      if (i % 64 == 0) bursty = ($urandom_range(0, 2) != 0);
      if (i == ITEM_COUNT / 2)
        drain_results();
      else if (bursty && i < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 12));
      random_key(typed, prior);
      key_in(typed, prior);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS hangul_syllable_composer_core");
    else
      $display("FAIL hangul_syllable_composer_core");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL hangul_syllable_composer_core");
    $finish;
  end

endmodule

/* sim.f */
src/hsc_pkg.sv
src/hsc_split.sv
src/hsc_compose.sv
src/hangul_syllable_composer_core.sv
verif/hangul_composition_checker.sv
verif/tb_hangul_syllable_composer_core.sv
